FILE: rtl/keyframe_curve_interpolator_assert.svh
// Assertion macros for the keyframe curve interpolator.
// No dependencies; included by the top level.
`ifndef KEYFRAME_CURVE_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_ASSERT_SVH

// cond must never hold outside reset
`define KCI_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("kci: never-condition hit");

// ante at one edge implies cons at the next edge
`define KCI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kci: next-cycle check failed");

`endif

FILE: rtl/kci_pkg.sv
// Shared constants, codes and controller/datapath types for the keyframe
// curve interpolator. No dependencies.
package kci_pkg;

  localparam int MAX_KEYS   = 16;
  localparam int KEY_IDX_W  = $clog2(MAX_KEYS);
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 40;
  localparam int U_W        = FRAC_BITS + 1;
  localparam int PROD_W     = ACC_W + U_W + 1;
  localparam int CNT_W      = 6;
  localparam int COUNT_W    = 5;

  localparam logic [CNT_W-1:0] MOD_STEPS  = CNT_W'(DATA_W);
  localparam logic [CNT_W-1:0] NDIV_STEPS = CNT_W'(U_W);

  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_COUNT = 2'd1;

  localparam logic [1:0]         MODE_RESET  = MODE_LINEAR;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CAPTURE,
    DP_LAST,
    DP_MOD,
    DP_SCAN0,
    DP_SCAN,
    DP_NDIV,
    DP_SETUP,
    DP_MUL,
    DP_ADD,
    DP_PUBLISH
  } dp_cmd_t;

  typedef struct packed {
    logic last_zero;
    logic cnt_done;
    logic scan_direct;
    logic scan_interp;
    logic last_round;
  } dp_status_t;

endpackage

FILE: rtl/kci_ctrl.sv
// Sequencing state machine for the keyframe curve interpolator.
// Depends on kci_pkg; drives the datapath command, reads its status.
module kci_ctrl import kci_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       cmd,
  input  logic       result_stall,
  input  dp_status_t status,
  output dp_cmd_t    dp_cmd,
  output logic       item_stall,
  output logic       result_valid
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LAST  = 10'b0000000010,
    S_MOD   = 10'b0000000100,
    S_SCAN0 = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_NDIV  = 10'b0000100000,
    S_SETUP = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_ADD   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_full;
  logic   publish;

  assign item_stall   = (state != S_IDLE);
  assign result_valid = out_full;
  // hand the result over when the output register is empty or draining
  assign publish      = (state == S_OUT) && (!out_full || !result_stall);

  always_comb begin
    state_next = state;
    dp_cmd     = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (cmd == CMD_EVAL) begin
            dp_cmd     = DP_CAPTURE;
            state_next = S_LAST;
          end else begin
            dp_cmd = DP_LOAD;
          end
        end
      end
      S_LAST: begin
        dp_cmd     = DP_LAST;
        state_next = status.last_zero ? S_SCAN0 : S_MOD;
      end
      S_MOD: begin
        dp_cmd = DP_MOD;
        if (status.cnt_done) state_next = S_SCAN0;
      end
      S_SCAN0: begin
        dp_cmd     = DP_SCAN0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        dp_cmd = DP_SCAN;
        if (status.scan_direct) state_next = S_OUT;
        else if (status.scan_interp) state_next = S_NDIV;
      end
      S_NDIV: begin
        dp_cmd = DP_NDIV;
        if (status.cnt_done) state_next = S_SETUP;
      end
      S_SETUP: begin
        dp_cmd     = DP_SETUP;
        state_next = S_MUL;
      end
      S_MUL: begin
        dp_cmd     = DP_MUL;
        state_next = S_ADD;
      end
      S_ADD: begin
        dp_cmd     = DP_ADD;
        state_next = status.last_round ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (publish) begin
          dp_cmd     = DP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (publish)           out_full <= 1'b1;
      else if (!result_stall) out_full <= 1'b0;
    end
  end

endmodule

FILE: rtl/kci_datapath.sv
// Key table, modulo and normalize dividers, scan compare and shared
// multiply-add unit. Depends on kci_pkg; sequenced by kci_ctrl.
module kci_datapath import kci_pkg::*; (
  input  logic                        clk,
  input  dp_cmd_t                     dp_cmd,
  input  logic [1:0]                  mode,
  input  logic [KEY_IDX_W-1:0]        n_m1,
  input  logic [KEY_IDX_W-1:0]        key_index,
  input  logic [DATA_W-1:0]           key_time,
  input  logic signed [DATA_W-1:0]    key_value,
  input  logic signed [DATA_W-1:0]    key_left_slope,
  input  logic signed [DATA_W-1:0]    key_right_slope,
  input  logic [DATA_W-1:0]           query_time,
  output dp_status_t                  status,
  output logic signed [DATA_W-1:0]    result
);

  // key table
  logic [DATA_W-1:0] mem_time [MAX_KEYS];
  logic [DATA_W-1:0] mem_val  [MAX_KEYS];
  logic [DATA_W-1:0] mem_ls   [MAX_KEYS];
  logic [DATA_W-1:0] mem_rs   [MAX_KEYS];
  logic [KEY_IDX_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_time, rd_val, rd_ls, rd_rs;

  logic [DATA_W-1:0]    q_shift, last_reg, t_reg, den;
  logic [DATA_W:0]      rem;
  logic [CNT_W-1:0]     cnt;
  logic [KEY_IDX_W-1:0] scan_idx;
  logic [DATA_W-1:0]    prev_time, prev_val, prev_rs;
  logic [DATA_W-1:0]    p0, p1, v0, v1;
  logic [U_W-1:0]       u;
  logic signed [ACC_W-1:0]  acc, b_reg;
  logic signed [PROD_W-1:0] prod;
  logic [1:0]           rnd;
  logic                 is_cubic;
  logic signed [DATA_W-1:0] res_work;

  function automatic logic signed [ACC_W-1:0] sx(input logic [DATA_W-1:0] v);
    sx = {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  always_comb begin
    case (dp_cmd)
      DP_CAPTURE: rd_addr = n_m1;
      DP_SCAN0:   rd_addr = '0;
      DP_SCAN:    rd_addr = scan_idx + KEY_IDX_W'(1);
      default:    rd_addr = scan_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd == DP_LOAD) begin
      mem_time[key_index] <= key_time;
      mem_val[key_index]  <= key_value;
      mem_ls[key_index]   <= key_left_slope;
      mem_rs[key_index]   <= key_right_slope;
    end
    rd_time <= mem_time[rd_addr];
    rd_val  <= mem_val[rd_addr];
    rd_ls   <= mem_ls[rd_addr];
    rd_rs   <= mem_rs[rd_addr];
  end

  // one restoring step of q mod last
  logic [DATA_W:0] mod_sh, mod_next;
  assign mod_sh   = {rem[DATA_W-1:0], q_shift[DATA_W-1]};
  assign mod_next = (mod_sh >= {1'b0, last_reg}) ? mod_sh - {1'b0, last_reg} : mod_sh;

  // one step of (t - t0) * 2^F / (t1 - t0)
  logic            nd_ge;
  logic [DATA_W:0] nd_rem;
  assign nd_ge  = (rem >= {1'b0, den});
  assign nd_rem = nd_ge ? rem - {1'b0, den} : rem;

  // scan decision on the entry just read
  logic first, at_last, pre_first, hit, zero_len;
  always_comb begin
    first     = (scan_idx == '0);
    at_last   = (scan_idx == n_m1);
    pre_first = first && (t_reg < rd_time);
    if (is_cubic) hit = !first && (rd_time > t_reg);
    else          hit = !first && (prev_time <= t_reg) && (rd_time >= t_reg);
    zero_len = (rd_time == prev_time);
  end
  assign is_cubic = (mode == MODE_CUBIC);

  logic step_hit;
  assign step_hit = (rd_time >= t_reg) || at_last;

  logic [DATA_W-1:0] direct_val;
  always_comb begin
    if (mode == MODE_STEP)  direct_val = rd_val;
    else if (pre_first)     direct_val = rd_val;
    else if (hit)           direct_val = prev_val;
    else                    direct_val = rd_val;
  end

  always_comb begin
    status.last_zero  = (rd_time == '0);
    status.cnt_done   = (cnt == CNT_W'(1));
    status.last_round = (rnd == 2'd0);
    if (mode == MODE_STEP) begin
      status.scan_direct = step_hit;
      status.scan_interp = 1'b0;
    end else begin
      status.scan_direct = pre_first || (hit && zero_len) || (!hit && at_last);
      status.scan_interp = !pre_first && hit && !zero_len;
    end
  end

  // multiply-add round
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  addend, sum;
  assign prod_sh = prod >>> FRAC_BITS;
  always_comb begin
    if (!is_cubic)          addend = sx(p0);
    else if (rnd == 2'd2)   addend = b_reg;
    else if (rnd == 2'd1)   addend = sx(v0);
    else                    addend = sx(p0);
  end
  assign sum = $signed(prod_sh[ACC_W-1:0]) + addend;

  logic overflow;
  assign overflow = !((&sum[ACC_W-1:DATA_W-1]) || !(|sum[ACC_W-1:DATA_W-1]));

  logic signed [ACC_W-1:0] a_val, b_val, d_val;
  assign d_val = sx(p1) - sx(p0);
  assign a_val = -(d_val <<< 1) + sx(v0) + sx(v1);
  assign b_val = d_val + (d_val <<< 1) - (sx(v0) <<< 1) - sx(v1);

  always_ff @(posedge clk) begin
    case (dp_cmd)
      DP_CAPTURE: q_shift <= query_time;
      DP_LAST: begin
        last_reg <= rd_time;
        t_reg    <= '0;
        rem      <= '0;
        cnt      <= MOD_STEPS;
      end
      DP_MOD: begin
        rem     <= mod_next;
        t_reg   <= mod_next[DATA_W-1:0];
        q_shift <= {q_shift[DATA_W-2:0], 1'b0};
        cnt     <= cnt - CNT_W'(1);
      end
      DP_SCAN0: scan_idx <= '0;
      DP_SCAN: begin
        scan_idx  <= scan_idx + KEY_IDX_W'(1);
        prev_time <= rd_time;
        prev_val  <= rd_val;
        prev_rs   <= rd_rs;
        res_work  <= direct_val;
        p0  <= prev_val;
        p1  <= rd_val;
        v0  <= prev_rs;
        v1  <= rd_ls;
        rem <= {1'b0, t_reg - prev_time};
        den <= rd_time - prev_time;
        cnt <= NDIV_STEPS;
        u   <= '0;
      end
      DP_NDIV: begin
        rem <= {nd_rem[DATA_W-1:0], 1'b0};
        u   <= {u[U_W-2:0], nd_ge};
        cnt <= cnt - CNT_W'(1);
      end
      DP_SETUP: begin
        acc   <= is_cubic ? a_val : d_val;
        b_reg <= b_val;
        rnd   <= is_cubic ? 2'd2 : 2'd0;
      end
      DP_MUL: prod <= acc * $signed({1'b0, u});
      DP_ADD: begin
        acc <= sum;
        rnd <= rnd - 2'd1;
        if (rnd == 2'd0) begin
          if (overflow) res_work <= sum[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                 : {1'b0, {(DATA_W-1){1'b1}}};
          else          res_work <= sum[DATA_W-1:0];
        end
      end
      DP_PUBLISH: result <= res_work;
      default: ;
    endcase
  end

endmodule

FILE: rtl/keyframe_curve_interpolator.sv
// Top level of the keyframe curve interpolator: ports, configuration
// registers, controller and datapath. Depends on kci_pkg, kci_ctrl,
// kci_datapath and keyframe_curve_interpolator_assert.svh.
//
// Usage:
//  - Item channel (item_valid/item_stall): cmd 0 loads keyframe key_index;
//    cmd 1 evaluates at query_time. Result channel (result_valid/
//    result_stall): one curve_value per evaluate item, none per load.
//  - Config channel (cfg_valid/cfg_ready, always ready): index 0 sets
//    interp_mode, index 1 sets key_count. Write only while idle.
//  - A load leaves the block idle; the next item is taken in the following cycle.
//  - An evaluate: read the last key, serial modulo of query_time by its time
//    (skipped for a zero last time), a scan over the keys, then for
//    linear/cubic with the query inside a non-empty interval a serial normalize
//    division, a setup step and a multiply and an add per round (1 linear,
//    3 cubic), then the hand-off to the output register.
//  - The item channel is free again from the edge that loads the result into
//    the output register; evaluate time is dominated by the two serial dividers.
//  - Results sit in an output register that holds while result_stall is
//    high; items keep being taken, and an evaluate that finishes while
//    the register is full and stalled waits there with the item channel stalled.
//  - Reset (rst, synchronous): idle, linear mode, key_count = 1; the key
//    table is not cleared.
module keyframe_curve_interpolator import kci_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     cmd,
  input  logic [KEY_IDX_W-1:0]     key_index,
  input  logic [DATA_W-1:0]        key_time,
  input  logic signed [DATA_W-1:0] key_value,
  input  logic signed [DATA_W-1:0] key_left_slope,
  input  logic signed [DATA_W-1:0] key_right_slope,
  input  logic [DATA_W-1:0]        query_time,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] curve_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [COUNT_W-1:0]       cfg_data
);

  `include "keyframe_curve_interpolator_assert.svh"

  logic [1:0]           interp_mode;
  logic [COUNT_W-1:0]   key_count;
  logic [KEY_IDX_W-1:0] n_m1;
  dp_cmd_t              dp_cmd;
  dp_status_t           status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= MODE_RESET;
      key_count   <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_MODE:  interp_mode <= cfg_data[1:0];
        CFG_IDX_COUNT: key_count   <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // index of the last key in use; zero counts as one, overflow clamps
  always_comb begin
    if (key_count == '0)                      n_m1 = '0;
    else if (key_count > COUNT_W'(MAX_KEYS))  n_m1 = KEY_IDX_W'(MAX_KEYS - 1);
    else                                      n_m1 = KEY_IDX_W'(key_count - COUNT_W'(1));
  end

  kci_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .cmd          (cmd),
    .result_stall (result_stall),
    .status       (status),
    .dp_cmd       (dp_cmd),
    .item_stall   (item_stall),
    .result_valid (result_valid)
  );

  kci_datapath u_dp (
    .clk             (clk),
    .dp_cmd          (dp_cmd),
    .mode            (interp_mode),
    .n_m1            (n_m1),
    .key_index       (key_index),
    .key_time        (key_time),
    .key_value       (key_value),
    .key_left_slope  (key_left_slope),
    .key_right_slope (key_right_slope),
    .query_time      (query_time),
    .status          (status),
    .result          (curve_value)
  );

  // handshake outputs are always known
  `KCI_ASSERT_NEVER(a_known_hs, clk, rst, $isunknown({item_stall, result_valid}))
  // after a load the item channel is free in the next cycle
  `KCI_ASSERT_NEXT(a_load_one_cycle, clk, rst, item_valid && !item_stall && !cmd, !item_stall)
  // an evaluate keeps the item channel busy in the next cycle
  `KCI_ASSERT_NEXT(a_eval_latency, clk, rst, item_valid && !item_stall && cmd, item_stall)
  // a stalled result holds
  `KCI_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, $stable(curve_value))

endmodule

FILE: test/kci_checker.sv
// Checker for the keyframe curve interpolator: watches the item, result and
// config channels, predicts curve values and compares them. Depends on kci_pkg.
module kci_checker import kci_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic                     cmd,
  input  logic [KEY_IDX_W-1:0]     key_index,
  input  logic [DATA_W-1:0]        key_time,
  input  logic signed [DATA_W-1:0] key_value,
  input  logic signed [DATA_W-1:0] key_left_slope,
  input  logic signed [DATA_W-1:0] key_right_slope,
  input  logic [DATA_W-1:0]        query_time,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic signed [DATA_W-1:0] curve_value,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [COUNT_W-1:0]       cfg_data,
  output int                       fail_count,
  output int                       pending
);

  logic [DATA_W-1:0]        times [MAX_KEYS];
  logic signed [DATA_W-1:0] values [MAX_KEYS];
  logic signed [DATA_W-1:0] lslope [MAX_KEYS];
  logic signed [DATA_W-1:0] rslope [MAX_KEYS];
  logic [1:0]               mode;
  logic [COUNT_W-1:0]       count;
  logic signed [DATA_W-1:0] curve_expect_q [$];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint norm_u(logic [31:0] t, logic [31:0] t0, logic [31:0] t1);
    logic [63:0] num;
    logic [63:0] den;
    num = {32'b0, t - t0} << FRAC_BITS;
    den = {32'b0, t1 - t0};
    return longint'(num / den);
  endfunction

  function automatic logic signed [31:0] curve_at(logic [31:0] q);
    int n;
    int e;
    logic [31:0] t;
    logic [31:0] last;
    longint p0, p1, v0, v1, a, b, u, r;
    n = (count == 0) ? 1 : ((count > MAX_KEYS) ? MAX_KEYS : int'(count));
    last = times[n-1];
    t = (last == 0) ? 32'd0 : q % last;
    if (mode == MODE_STEP) begin
      for (int i = 0; i < n; i++)
        if (times[i] >= t) return values[i];
      return values[n-1];
    end
    if (t < times[0]) return values[0];
    if (mode == MODE_CUBIC) begin
      e = n;
      for (int i = 0; i < n; i++)
        if (times[i] > t) begin
          e = i;
          break;
        end
      if (e == 0) return values[0];
      if (e == n) return values[e-1];
      p0 = values[e-1];
      if (times[e] == times[e-1]) return p0;
      p1 = values[e];
      v0 = rslope[e-1];
      v1 = lslope[e];
      u  = norm_u(t, times[e-1], times[e]);
      a  = 2 * (p0 - p1) + v0 + v1;
      b  = 3 * (p1 - p0) - 2 * v0 - v1;
      r  = ((a * u) >>> FRAC_BITS) + b;
      r  = ((r * u) >>> FRAC_BITS) + v0;
      r  = ((r * u) >>> FRAC_BITS) + p0;
      return 32'(clamp32(r));
    end
    // linear, and the spare selector value
    for (int i = 0; i + 1 < n; i++) begin
      if (times[i] <= t && times[i+1] >= t) begin
        p0 = values[i];
        p1 = values[i+1];
        if (times[i+1] == times[i]) return p0;
        u = norm_u(t, times[i], times[i+1]);
        return 32'(clamp32(p0 + ((u * (p1 - p0)) >>> FRAC_BITS)));
      end
    end
    return values[n-1];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_RESET;
      count <= COUNT_RESET;
      curve_expect_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_MODE) mode <= cfg_data[1:0];
        else if (cfg_index == CFG_IDX_COUNT) count <= cfg_data;
      end
      if (result_valid && !result_stall) begin
        if (curve_expect_q.size() == 0) begin
          $error("unexpected result: curve_value %0d", curve_value);
          fail_count <= fail_count + 1;
        end else begin
          if (curve_value !== curve_expect_q[0]) begin
            $error("curve_value mismatch: expected %0d actual %0d",
                   curve_expect_q[0], curve_value);
            fail_count <= fail_count + 1;
          end
          void'(curve_expect_q.pop_front());
        end
      end
      if (item_valid && !item_stall) begin
        if (cmd == CMD_LOAD) begin
          times[key_index]  = key_time;
          values[key_index] = key_value;
          lslope[key_index] = key_left_slope;
          rslope[key_index] = key_right_slope;
        end else begin
          curve_expect_q = {curve_expect_q, curve_at(query_time)};
        end
      end
      pending <= curve_expect_q.size();
    end
  end

endmodule

FILE: test/tb_keyframe_curve_interpolator.sv
// Testbench top for the keyframe curve interpolator: clock, reset, stimulus
// and verdict. Depends on kci_pkg, kci_checker and the block itself.
module tb_keyframe_curve_interpolator;
  import kci_pkg::*;

  localparam int LIMIT = 2000000;

  logic                     clk;
  logic                     rst;
  logic                     item_valid;
  logic                     item_stall;
  logic                     cmd;
  logic [KEY_IDX_W-1:0]     key_index;
  logic [DATA_W-1:0]        key_time;
  logic signed [DATA_W-1:0] key_value;
  logic signed [DATA_W-1:0] key_left_slope;
  logic signed [DATA_W-1:0] key_right_slope;
  logic [DATA_W-1:0]        query_time;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [DATA_W-1:0] curve_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [COUNT_W-1:0]       cfg_data;
  int                       fail_count;
  int                       pending;

  bit  calm;       // no random idling on either side
  bit  hold_req;   // asks for one long receiver hold-off
  bit  hold_off;
  int  cycles;
  int  items_sent;
  logic [31:0] slot_time [MAX_KEYS];  // our copy of loaded key times, for queries

  keyframe_curve_interpolator dut (.*);

  kci_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // cycle limit: a hang anywhere lands here
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("FAIL keyframe_curve_interpolator");
        $finish;
      end
    end
  end

  // receiver: random stall, plus a forced hold-off while hold_off is set
  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else if (hold_off) result_stall <= 1'b1;
    else if (calm) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(0, 99) < 10);
  end

  // long hold-off counted here, so the sender keeps pushing and the block backs up
  initial begin
    hold_off = 0;
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (400) @(posedge clk);
      hold_off <= 1'b0;
      hold_req = 0;
    end
  end

  task automatic send(bit c, logic [3:0] idx, logic [31:0] kt, logic [31:0] kv,
                      logic [31:0] kl, logic [31:0] kr, logic [31:0] q);
    bit ok;
    if (!calm && $urandom_range(0, 99) < 10) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid      <= 1'b1;
    cmd             <= c;
    key_index       <= idx;
    key_time        <= kt;
    key_value       <= kv;
    key_left_slope  <= kl;
    key_right_slope <= kr;
    query_time      <= q;
    do begin
      @(negedge clk);
      ok = !item_stall;
      @(posedge clk);
    end while (!ok);
    items_sent++;
  endtask

  task automatic load_key(logic [3:0] idx, logic [31:0] kt, logic [31:0] kv,
                          logic [31:0] kl, logic [31:0] kr);
    slot_time[idx] = kt;
    send(CMD_LOAD, idx, kt, kv, kl, kr, $urandom());
  endtask

  task automatic eval_at(logic [31:0] q);
    send(CMD_EVAL, 4'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(), q);
  endtask

  // quiet point: all results back, then room for an evaluate still running
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [COUNT_W-1:0] d);
    bit ok;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_slope();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
  endfunction

  // kind 0: ascending times; 1: arbitrary order; 2: ascending with repeats from 0
  task automatic load_table(int kind);
    logic [31:0] t;
    logic [31:0] span;
    span = ($urandom_range(0, 3) == 0) ? 32'h0FFF_FFFF : $urandom_range(1, 32'h0004_0000);
    t = (kind == 2) ? 32'd0 : $urandom_range(0, span);
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (kind == 1) t = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, span);
      load_key(4'(i), t, rand_value(), rand_slope(), rand_slope());
      if (kind == 2 && $urandom_range(0, 2) == 0) t = t;
      else t = t + $urandom_range(1, span);
    end
  endtask

  function automatic logic [31:0] rand_query();
    int k;
    k = $urandom_range(0, MAX_KEYS - 1);
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return slot_time[k];
      2: return slot_time[k] + 32'($urandom_range(0, 2)) - 32'd1;
      default: return $urandom_range(0, slot_time[MAX_KEYS-1]);
    endcase
  endfunction

  initial begin
    logic [4:0] n;
    int phase;
    rst             <= 1'b1;
    item_valid      <= 1'b0;
    cmd             <= CMD_LOAD;
    key_index       <= '0;
    key_time        <= '0;
    key_value       <= '0;
    key_left_slope  <= '0;
    key_right_slope <= '0;
    query_time      <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_IDX_MODE;
    cfg_data        <= '0;
    calm = 0;
    hold_req = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every slot written first, so no read ever sees an unwritten entry.
    // Value and slope extremes push the cubic and linear paths into saturation.
    for (int i = 0; i < MAX_KEYS; i++)
      load_key(4'(i), 32'h0001_0000 * (i + 1), (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
               (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
    eval_at(32'h0000_8000);          // count 1 at reset, linear
    write_reg(CFG_IDX_COUNT, 5'd16);
    eval_at(32'd0);                  // before first key
    eval_at(32'hFFFF_FFFF);          // wraps
    eval_at(32'h0002_8000);          // mid interval
    eval_at(32'h0003_0000);          // exactly on a key
    write_reg(CFG_IDX_MODE, 5'(MODE_STEP));
    eval_at(32'h0002_8000);
    eval_at(32'h000F_FFFF);
    write_reg(CFG_IDX_MODE, 5'(MODE_CUBIC));
    eval_at(32'h0002_4000);
    eval_at(32'h0005_C000);
    load_key(4'd3, 32'h0003_0000, 32'h1234_5678, 32'h0, 32'h0);  // zero-length interval
    eval_at(32'h0003_0000);
    write_reg(CFG_IDX_MODE, 5'd3);   // spare selector
    eval_at(32'h0003_0000);
    eval_at(32'h0007_1234);
    load_key(4'd0, 32'd0, 32'h0ABC_0000, 32'h0, 32'h0);           // zero last time
    write_reg(CFG_IDX_COUNT, 5'd1);
    eval_at(32'hDEAD_BEEF);
    write_reg(CFG_IDX_COUNT, 5'd0);  // counts as one
    eval_at(32'h0000_0001);
    write_reg(CFG_IDX_COUNT, 5'd31); // counts as the full table
    eval_at(32'h0004_0000);

    // Random phases: mostly well-formed ascending tables, some arbitrary order.
    phase = 0;
    while (items_sent < 1500) begin
      calm = (phase == 3 || phase == 4);
      write_reg(CFG_IDX_MODE, 5'($urandom_range(0, 3)));
      if ($urandom_range(0, 4) == 0) begin
        n = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 1));
      end else begin
        n = 5'($urandom_range(2, 16));
      end
      write_reg(CFG_IDX_COUNT, n);
      case ($urandom_range(0, 5))
        0: load_table(1);
        1: load_table(2);
        default: load_table(0);
      endcase
      if (phase == 5) hold_req = 1;
      repeat ($urandom_range(20, 40)) begin
        if ($urandom_range(0, 19) == 0)
          load_key(4'($urandom_range(0, MAX_KEYS - 1)), rand_query(), rand_value(),
                   rand_slope(), rand_slope());
        else eval_at(rand_query());
      end
      if (phase == 8) drain();
      phase++;
    end

    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("PASS keyframe_curve_interpolator");
    else $display("FAIL keyframe_curve_interpolator");
    $finish;
  end

endmodule

FILE: keyframe_curve_interpolator.f
+incdir+rtl
rtl/kci_pkg.sv
rtl/kci_ctrl.sv
rtl/kci_datapath.sv
rtl/keyframe_curve_interpolator.sv
test/kci_checker.sv
test/tb_keyframe_curve_interpolator.sv
